FILE: rtl/gfw_pkg.sv
// Shared constants for the 5x5 Gaussian window filter: field widths, register
// indexes and reset values, kernel weights and the divide-by-330 reciprocal.
// No dependencies.
package gfw_pkg;

	localparam int PIX_W      = 8;
	localparam int ROW_W      = 12;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MIN_DIM       = 5;
	localparam int MAX_HEIGHT    = 4096;
	localparam int WIN           = 5;

	localparam logic [IMG_W_W-1:0] RESET_WIDTH  = 11'd640;
	localparam logic [IMG_H_W-1:0] RESET_HEIGHT = 13'd480;

	localparam int SUM_W = 17;

	localparam logic [SUM_W-1:0] K_W4  = 17'd4;
	localparam logic [SUM_W-1:0] K_W7  = 17'd7;
	localparam logic [SUM_W-1:0] K_W20 = 17'd20;
	localparam logic [SUM_W-1:0] K_W33 = 17'd33;
	localparam logic [SUM_W-1:0] K_W54 = 17'd54;

	localparam int RECIP_W   = 18;
	localparam int DIV_SHIFT = 26;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 18'd203361;

	typedef logic [PIX_W-1:0] pix_t;

endpackage

FILE: rtl/gfw_pix_if.sv
// Pixel input channel of the Gaussian window filter.
// Depends on gfw_pkg.
interface gfw_pix_if;
	logic          valid;
	logic          ready;
	gfw_pkg::pix_t pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

FILE: rtl/gfw_res_if.sv
// Result channel of the Gaussian window filter: filtered value, centre
// coordinates and end-of-frame flag. Depends on gfw_pkg.
interface gfw_res_if #(
	parameter int COL_W = $clog2(gfw_pkg::MAX_WIDTH_DEF)
);
	logic                      valid;
	logic                      ready;
	gfw_pkg::pix_t             filtered;
	logic [COL_W-1:0]          center_col;
	logic [gfw_pkg::ROW_W-1:0] center_row;
	logic                      frame_done;

	modport source (output valid, output filtered, output center_col, output center_row,
		output frame_done, input ready);
	modport sink (input valid, input filtered, input center_col, input center_row,
		input frame_done, output ready);
endinterface

FILE: rtl/gaussian_5x5_window_filter_core.sv
// Throughput: one pixel per cycle while no stall from the result channel holds the pipeline,
// set by the single line-store read and write in each cycle.
// Each stage holds only while the stage after it is full and stalled.
// Reset clears the counters, stage valids and registers (640 x 480); the line store is
// not cleared, so the first rows after reset read whatever the store held before it.
// Depends on gfw_pkg, gfw_pix_if and gfw_res_if.
module gaussian_5x5_window_filter_core #(
	parameter int MAX_WIDTH = gfw_pkg::MAX_WIDTH_DEF,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [gfw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gfw_pkg::CFG_DATA_W-1:0] cfg_data,
	gfw_pix_if.sink                        pix,
	gfw_res_if.source                      res
);

	localparam int WW = COL_W + 1;
	localparam int HW = gfw_pkg::IMG_H_W;
	localparam int PW = gfw_pkg::PIX_W;
	localparam int CW = PW * (gfw_pkg::WIN - 1);
	localparam int WCW = PW * gfw_pkg::WIN;
	localparam int PRW = gfw_pkg::SUM_W + gfw_pkg::RECIP_W;

	typedef struct packed {
		logic [COL_W-1:0]          ccol;
		logic [gfw_pkg::ROW_W-1:0] crow;
		logic                      last;
	} meta_t;

	logic [gfw_pkg::IMG_W_W-1:0] image_width_q;
	logic [gfw_pkg::IMG_H_W-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= gfw_pkg::RESET_WIDTH;
			image_height_q <= gfw_pkg::RESET_HEIGHT;
		end else if (cfg_write) begin
			case (cfg_index)
				gfw_pkg::CFG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[gfw_pkg::IMG_W_W-1:0];
				end
				gfw_pkg::CFG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[gfw_pkg::IMG_H_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	logic [WW-1:0] used_w;
	logic [HW-1:0] used_h;

	always_comb begin
		int iw;
		int ih;
		iw = 32'(image_width_q);
		ih = 32'(image_height_q);
		if (iw < gfw_pkg::MIN_DIM) begin
			used_w = WW'(gfw_pkg::MIN_DIM);
		end else if (iw > MAX_WIDTH) begin
			used_w = WW'(MAX_WIDTH);
		end else begin
			used_w = WW'(iw);
		end
		if (ih < gfw_pkg::MIN_DIM) begin
			used_h = HW'(gfw_pkg::MIN_DIM);
		end else if (ih > gfw_pkg::MAX_HEIGHT) begin
			used_h = HW'(gfw_pkg::MAX_HEIGHT);
		end else begin
			used_h = HW'(ih);
		end
	end

	logic v1_s1, v2_s2, v3_s3, v4_s4, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_out;
	logic accept, adv1;

	logic emit_s2;

	assign rdy_out = !out_valid_q || res.ready;
	assign rdy4    = !v4_s4 || rdy_out;
	assign rdy3    = !v3_s3 || rdy4;
	assign rdy2    = !v2_s2 || !emit_s2 || rdy3;
	assign rdy1    = !v1_s1 || rdy2;
	assign adv1    = v1_s1 && rdy2;
	assign accept  = pix.valid && rdy1;
	assign pix.ready = rdy1;

	logic [COL_W-1:0]          col_q;
	logic [gfw_pkg::ROW_W-1:0] row_q;
	logic [WW-1:0]             col_p1;
	logic [HW-1:0]             row_p1;
	logic                      line_end, frame_end;

	assign col_p1    = {1'b0, col_q} + WW'(1);
	assign row_p1    = {1'b0, row_q} + HW'(1);
	assign line_end  = col_p1 >= used_w;
	assign frame_end = row_p1 >= used_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_p1[gfw_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_p1[COL_W-1:0];
			end
		end
	end

	logic [CW-1:0]    line_mem [MAX_WIDTH];
	logic [CW-1:0]    rd_s1;
	gfw_pkg::pix_t    px_s1;
	logic [COL_W-1:0] col_s1;
	meta_t            meta_s1, meta_s2, meta_s3, meta_s4;
	logic             emit_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			line_mem[col_s1] <= {rd_s1[CW-PW-1:0], px_s1};
		end
		if (accept) begin
			rd_s1 <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1        <= pix.pixel;
			col_s1       <= col_q;
			emit_s1      <= (col_q >= COL_W'(4)) && (row_q >= gfw_pkg::ROW_W'(4));
			meta_s1.ccol <= col_q - COL_W'(2);
			meta_s1.crow <= row_q - gfw_pkg::ROW_W'(2);
			meta_s1.last <= line_end && frame_end;
		end
	end

	logic [WCW-1:0] win_q [gfw_pkg::WIN];

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int k = 0; k < gfw_pkg::WIN - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[gfw_pkg::WIN-1] <= {rd_s1, px_s1};
			meta_s2 <= meta_s1;
			emit_s2 <= emit_s1;
		end
	end

	gfw_pkg::pix_t px [gfw_pkg::WIN][gfw_pkg::WIN];

	always_comb begin
		for (int r = 0; r < gfw_pkg::WIN; r++) begin
			for (int c = 0; c < gfw_pkg::WIN; c++) begin
				px[r][c] = win_q[c][PW*(gfw_pkg::WIN-1-r) +: PW];
			end
		end
	end

	logic [9:0]  g1_s3, g7_s3, g20_s3, g33_s3;
	logic [10:0] g4_s3;
	logic [7:0]  g54_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v2_s2 && emit_s2) begin
			g1_s3  <= 10'(px[0][0]) + 10'(px[0][4]) + 10'(px[4][0]) + 10'(px[4][4]);
			g4_s3  <= 11'(px[0][1]) + 11'(px[0][3]) + 11'(px[4][1]) + 11'(px[4][3])
				+ 11'(px[1][0]) + 11'(px[3][0]) + 11'(px[1][4]) + 11'(px[3][4]);
			g7_s3  <= 10'(px[0][2]) + 10'(px[4][2]) + 10'(px[2][0]) + 10'(px[2][4]);
			g20_s3 <= 10'(px[1][1]) + 10'(px[1][3]) + 10'(px[3][1]) + 10'(px[3][3]);
			g33_s3 <= 10'(px[1][2]) + 10'(px[3][2]) + 10'(px[2][1]) + 10'(px[2][3]);
			g54_s3 <= px[2][2];
			meta_s3 <= meta_s2;
		end
	end

	logic [gfw_pkg::SUM_W-1:0] wsum_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v3_s3) begin
			wsum_s4 <= gfw_pkg::SUM_W'(g1_s3)
				+ gfw_pkg::SUM_W'(g4_s3) * gfw_pkg::K_W4
				+ gfw_pkg::SUM_W'(g7_s3) * gfw_pkg::K_W7
				+ gfw_pkg::SUM_W'(g20_s3) * gfw_pkg::K_W20
				+ gfw_pkg::SUM_W'(g33_s3) * gfw_pkg::K_W33
				+ gfw_pkg::SUM_W'(g54_s3) * gfw_pkg::K_W54;
			meta_s4 <= meta_s3;
		end
	end

	logic [PRW-1:0] prod;
	gfw_pkg::pix_t  filtered_q;
	meta_t          meta_q;

	assign prod = PRW'(wsum_s4) * PRW'(gfw_pkg::DIV_RECIP);

	always_ff @(posedge clk) begin
		if (rdy_out && v4_s4) begin
			filtered_q <= prod[gfw_pkg::DIV_SHIFT +: PW];
			meta_q     <= meta_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			v4_s4       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_s1 <= pix.valid;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
			if (rdy3) begin
				v3_s3 <= v2_s2 && emit_s2;
			end
			if (rdy4) begin
				v4_s4 <= v3_s3;
			end
			if (rdy_out) begin
				out_valid_q <= v4_s4;
			end
		end
	end

	assign res.valid      = out_valid_q;
	assign res.filtered   = filtered_q;
	assign res.center_col = meta_q.ccol;
	assign res.center_row = meta_q.crow;
	assign res.frame_done = meta_q.last;

	// A line-store read and the write-back of the item ahead never address the same column.
	a_no_addr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && adv1) |-> (col_q != col_s1))
		else $error("line store read and write address the same column");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_s1 && !rdy2) |=> (v1_s1 && $stable(col_s1) && $stable(px_s1)))
		else $error("first stage lost its item while stalled");

	a_out_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy_out && !v4_s4) |=> !out_valid_q)
		else $error("output register offered a result without a source");

endmodule

FILE: tb/gaussian_5x5_window_filter_core_tb.sv
// Self-checking testbench for gaussian_5x5_window_filter_core: a pixel driver and a result
// monitor compare every transfer with a behavioural copy of the filter.
// Depends on gfw_pkg, gfw_pix_if, gfw_res_if and the filter core itself.
module gaussian_5x5_window_filter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COL_BITS       = $clog2(gfw_pkg::MAX_WIDTH_DEF);
	localparam int GAUSS_DIVISOR  = 330;
	localparam int DRAIN_SLACK    = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PIXELS  = 650;

	typedef struct packed {
		gfw_pkg::pix_t             filtered;
		logic [COL_BITS-1:0]       center_col;
		logic [gfw_pkg::ROW_W-1:0] center_row;
		logic                      frame_done;
	} gauss_result_t;

	typedef enum logic [1:0] {STYLE_NOISE, STYLE_EXTREME, STYLE_RAMP, STYLE_FLAT} pix_style_t;
	typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_BURSTY} ready_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_write;
	logic [gfw_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [gfw_pkg::CFG_DATA_W-1:0] cfg_data;

	gfw_pix_if pix_ch ();
	gfw_res_if res_ch ();

	gaussian_5x5_window_filter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix_ch),
		.res       (res_ch)
	);

	always #6 clk = ~clk;

	// Filter state as seen from outside: line store, window, position and geometry.
	logic [31:0]                 line_mem [gfw_pkg::MAX_WIDTH_DEF];
	logic [39:0]                 win_cols [gfw_pkg::WIN];
	int unsigned                 next_col;
	int unsigned                 next_row;
	logic [gfw_pkg::IMG_W_W-1:0] width_reg;
	logic [gfw_pkg::IMG_H_W-1:0] height_reg;

	gauss_result_t expected_results [$];
	gfw_pkg::pix_t pixel_queue [$];
	int unsigned   pixels_queued   = 0;
	int unsigned   pixels_accepted = 0;
	int unsigned   pixels_offered  = 0;
	int unsigned   mismatch_count  = 0;
	int unsigned   quiet_cycles    = 0;

	int unsigned   burst_left = 0;
	int unsigned   gap_left   = 0;
	logic          drain_hold = 1'b0;
	ready_mode_t   ready_mode = READY_ALWAYS;
	int unsigned   mode_left  = 0;
	int unsigned   stall_left = 0;

	function automatic int unsigned clamp_width(input logic [gfw_pkg::IMG_W_W-1:0] raw);
		if (raw < gfw_pkg::MIN_DIM)
			return gfw_pkg::MIN_DIM;
		if (raw > gfw_pkg::MAX_WIDTH_DEF)
			return gfw_pkg::MAX_WIDTH_DEF;
		return raw;
	endfunction

	function automatic int unsigned clamp_height(input logic [gfw_pkg::IMG_H_W-1:0] raw);
		if (raw < gfw_pkg::MIN_DIM)
			return gfw_pkg::MIN_DIM;
		if (raw > gfw_pkg::MAX_HEIGHT)
			return gfw_pkg::MAX_HEIGHT;
		return raw;
	endfunction

	function automatic int unsigned gauss_weight(input int ry, input int cx);
		int r;
		int c;
		int t;
		r = (ry > 2) ? 4 - ry : ry;
		c = (cx > 2) ? 4 - cx : cx;
		if (r > c) begin
			t = r;
			r = c;
			c = t;
		end
		case (r * 3 + c)
			0: return 1;
			1: return 4;
			2: return 7;
			4: return 20;
			5: return 33;
			default: return 54;
		endcase
	endfunction

	task automatic predict_pixel(input gfw_pkg::pix_t px);
		logic [31:0]   stored;
		int unsigned   w;
		int unsigned   h;
		int unsigned   sum;
		gauss_result_t r;
		w = clamp_width(width_reg);
		h = clamp_height(height_reg);
		stored = line_mem[next_col];
		line_mem[next_col] = {stored[23:0], px};
		for (int k = 0; k < gfw_pkg::WIN - 1; k++)
			win_cols[k] = win_cols[k + 1];
		win_cols[gfw_pkg::WIN - 1] = {stored, px};
		if (next_col >= 4 && next_row >= 4) begin
			sum = 0;
			for (int cx = 0; cx < gfw_pkg::WIN; cx++)
				for (int ry = 0; ry < gfw_pkg::WIN; ry++)
					sum += win_cols[cx][8 * (4 - ry) +: 8] * gauss_weight(ry, cx);
			r.filtered   = gfw_pkg::pix_t'(sum / GAUSS_DIVISOR);
			r.center_col = COL_BITS'(next_col - 2);
			r.center_row = gfw_pkg::ROW_W'(next_row - 2);
			r.frame_done = (next_col + 1 >= w) && (next_row + 1 >= h);
			expected_results.push_back(r);
		end
		if (next_col + 1 >= w) begin
			next_col = 0;
			next_row = (next_row + 1 >= h) ? 0 : next_row + 1;
		end else begin
			next_col = next_col + 1;
		end
	endtask

	function automatic int unsigned pixels_to_frame_end();
		int unsigned c;
		int unsigned r;
		int unsigned w;
		int unsigned h;
		int unsigned n;
		c = next_col;
		r = next_row;
		w = clamp_width(width_reg);
		h = clamp_height(height_reg);
		n = 0;
		do begin
			n++;
			if (c + 1 >= w) begin
				c = 0;
				r = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				c++;
			end
		end while (c != 0 || r != 0);
		return n;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		mismatch_count++;
	endtask

	task automatic write_reg(input logic [gfw_pkg::CFG_IDX_W-1:0] index,
			input logic [gfw_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (index == gfw_pkg::CFG_IMAGE_WIDTH)
			width_reg = data[gfw_pkg::IMG_W_W-1:0];
		else
			height_reg = data[gfw_pkg::IMG_H_W-1:0];
	endtask

	task automatic queue_pixels(input int unsigned count, input pix_style_t style);
		gfw_pkg::pix_t level;
		gfw_pkg::pix_t stride;
		level  = gfw_pkg::pix_t'($urandom);
		stride = gfw_pkg::pix_t'($urandom_range(1, 9));
		for (int unsigned i = 0; i < count; i++) begin
			case (style)
				STYLE_EXTREME: pixel_queue.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
				STYLE_RAMP: begin
					pixel_queue.push_back(level);
					level = level + stride;
				end
				STYLE_FLAT: pixel_queue.push_back(level ^ gfw_pkg::pix_t'($urandom_range(0, 3)));
				default: pixel_queue.push_back(gfw_pkg::pix_t'($urandom));
			endcase
		end
		pixels_queued += count;
	endtask

	task automatic wait_drained();
		while (pixels_accepted != pixels_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	function automatic logic [gfw_pkg::CFG_DATA_W-1:0] random_width_word();
		logic [gfw_pkg::CFG_DATA_W-1:0] word;
		word = gfw_pkg::CFG_DATA_W'($urandom);
		case ($urandom_range(0, 9))
			0: word[gfw_pkg::IMG_W_W-1:0] = gfw_pkg::IMG_W_W'($urandom_range(0, 4));
			1: word[gfw_pkg::IMG_W_W-1:0] = gfw_pkg::IMG_W_W'($urandom_range(13, 48));
			default: word[gfw_pkg::IMG_W_W-1:0] = gfw_pkg::IMG_W_W'($urandom_range(5, 12));
		endcase
		return word;
	endfunction

	function automatic logic [gfw_pkg::CFG_DATA_W-1:0] random_height_word();
		case ($urandom_range(0, 9))
			0: return gfw_pkg::CFG_DATA_W'($urandom_range(0, 4));
			1: return gfw_pkg::CFG_DATA_W'($urandom_range(10, 30));
			2: return gfw_pkg::CFG_DATA_W'($urandom_range(4097, 8191));
			default: return gfw_pkg::CFG_DATA_W'($urandom_range(5, 9));
		endcase
	endfunction

	// Pixel driver: bursts of transfers separated by random gaps, with occasional holds until drained.
	always @(posedge clk) begin
		logic offer;
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				predict_pixel(pix_ch.pixel);
				pixels_accepted++;
			end
			if (!pix_ch.valid || pix_ch.ready) begin
				offer = 1'b0;
				if (drain_hold) begin
					if (expected_results.size() == 0)
						drain_hold = 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
				end else if (pixel_queue.size() > 0) begin
					offer = 1'b1;
					pix_ch.pixel <= pixel_queue.pop_front();
					pixels_offered++;
					if (pixels_offered == 400 || $urandom_range(0, 299) == 0)
						drain_hold = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						if ($urandom_range(0, 2) == 0)
							gap_left = 0;
						else
							gap_left = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 6);
					end
				end
				pix_ch.valid <= offer;
			end
		end
	end

	// Result monitor with its own stall pattern.
	always @(posedge clk) begin
		gauss_result_t seen;
		gauss_result_t want;
		logic          next_ready;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				seen.filtered   = res_ch.filtered;
				seen.center_col = res_ch.center_col;
				seen.center_row = res_ch.center_row;
				seen.frame_done = res_ch.frame_done;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d at col %0d row %0d done %0b",
						seen.filtered, seen.center_col, seen.center_row, seen.frame_done));
				end else begin
					want = expected_results.pop_front();
					if (seen.filtered !== want.filtered || seen.center_col !== want.center_col
							|| seen.center_row !== want.center_row
							|| seen.frame_done !== want.frame_done)
						report_mismatch($sformatf(
							"got %0d col %0d row %0d done %0b, want %0d col %0d row %0d done %0b",
							seen.filtered, seen.center_col, seen.center_row, seen.frame_done,
							want.filtered, want.center_col, want.center_row, want.frame_done));
				end
			end
			if (mode_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end
			case (ready_mode)
				READY_ALWAYS: next_ready = 1'b1;
				READY_COIN: next_ready = $urandom_range(0, 1);
				READY_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						next_ready = 1'b0;
					end else begin
						next_ready = 1'b1;
						if ($urandom_range(0, 15) == 0)
							stall_left = $urandom_range(5, 25);
					end
				end
			endcase
			res_ch.ready <= next_ready;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("gaussian_5x5_window_filter_core_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned                    random_queued;
		int unsigned                    remaining;
		int unsigned                    count;
		logic [gfw_pkg::CFG_DATA_W-1:0] word;
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = gfw_pkg::CFG_IMAGE_WIDTH;
		cfg_data  = '0;
		foreach (line_mem[i])
			line_mem[i] = '0;
		foreach (win_cols[i])
			win_cols[i] = '0;
		next_col   = 0;
		next_row   = 0;
		width_reg  = gfw_pkg::RESET_WIDTH;
		height_reg = gfw_pkg::RESET_HEIGHT;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry: part of a first line, then the line is narrowed and the frame cut short.
		queue_pixels(60, STYLE_NOISE);
		wait_drained();
		write_reg(gfw_pkg::CFG_IMAGE_WIDTH, gfw_pkg::CFG_DATA_W'(6));
		write_reg(gfw_pkg::CFG_IMAGE_HEIGHT, gfw_pkg::CFG_DATA_W'(5));
		queue_pixels(pixels_to_frame_end(), STYLE_RAMP);
		wait_drained();

		// Out-of-range values clamp to the smallest frame; one dark corner among white pixels.
		write_reg(gfw_pkg::CFG_IMAGE_WIDTH, 13'h1803);
		write_reg(gfw_pkg::CFG_IMAGE_HEIGHT, gfw_pkg::CFG_DATA_W'(2));
		pixel_queue.push_back(8'h00);
		repeat (24) pixel_queue.push_back(8'hFF);
		pixels_queued += 25;

		random_queued = 0;
		while (random_queued < RANDOM_PIXELS) begin
			wait_drained();
			if (next_col == 0 && next_row == 0) begin
				if ($urandom_range(0, 3) != 0)
					write_reg(gfw_pkg::CFG_IMAGE_WIDTH, random_width_word());
				if ($urandom_range(0, 3) != 0)
					write_reg(gfw_pkg::CFG_IMAGE_HEIGHT, random_height_word());
			end else begin
				case ($urandom_range(0, 3))
					0: write_reg(gfw_pkg::CFG_IMAGE_HEIGHT, random_height_word());
					1: begin
						// Only a line no wider than the current one is safe mid-frame: wider columns hold no history.
						word = random_width_word();
						if (clamp_width(word[gfw_pkg::IMG_W_W-1:0]) <= clamp_width(width_reg))
							write_reg(gfw_pkg::CFG_IMAGE_WIDTH, word);
					end
					default: ;
				endcase
			end
			remaining = pixels_to_frame_end();
			if (remaining <= 300 && $urandom_range(0, 3) != 0)
				count = remaining;
			else
				count = $urandom_range(1, 3 * clamp_width(width_reg));
			queue_pixels(count, pix_style_t'($urandom_range(0, 3)));
			random_queued += count;
		end

		wait_drained();
		write_reg(gfw_pkg::CFG_IMAGE_HEIGHT, gfw_pkg::CFG_DATA_W'(5));
		queue_pixels(pixels_to_frame_end(), STYLE_NOISE);
		wait_drained();

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("gaussian_5x5_window_filter_core_tb passed");
		else
			$display("gaussian_5x5_window_filter_core_tb failed");
		$finish;
	end

endmodule
